/* src/hashed_timing_wheel_defines.svh */
// Assertion macros shared by the timing wheel modules.
`ifndef HASHED_TIMING_WHEEL_DEFINES_SVH
`define HASHED_TIMING_WHEEL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HTW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HTW_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HTW_ASSERT(lbl, clk, rst, prop, msg)
`define HTW_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* src/htw_pkg.sv */
// Shared types and codes of the hashed timing wheel.
package htw_pkg;
  typedef enum logic [1:0] {
    OP_TICK = 2'd0, OP_REG = 2'd1, OP_DEREG = 2'd2, OP_RESCHED = 2'd3
  } op_t;
  typedef enum logic [1:0] {
    KIND_FIRED = 2'd0, KIND_REGISTERED = 2'd1, KIND_FULL = 2'd2
  } kind_t;
  localparam logic CFG_WHEEL_SLOTS = 1'b0;
  localparam logic CFG_TICK_PERIOD = 1'b1;
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  timer_id;
    logic [23:0] interval;
    logic        recurring;
  } cmd_t;
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] entry_id;
    logic       last;
  } res_t;
  typedef enum logic [3:0] {
    ST_IDLE, ST_ADV, ST_SCAN, ST_DIV_INIT, ST_DIV, ST_MUL, ST_PLACE_DIV, ST_PLACE_RUN,
    ST_PLACE_DONE, ST_EMIT, ST_WRAP, ST_WRAP_DONE
  } state_t;
endpackage

/* src/htw_front.sv */
// Input side: registers commands into a short queue for the back end.
module htw_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  output logic            s_ready,
  input  htw_pkg::cmd_t   s_cmd,
  output logic            q_valid,
  input  logic            q_ready,
  output htw_pkg::cmd_t   q_cmd
);
  // Two-entry queue.
  htw_pkg::cmd_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign s_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      mem[wr_ptr] <= s_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (s_valid && s_ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'((s_valid && s_ready) ? 1 : 0) - 2'((q_valid && q_ready) ? 1 : 0);
    end
  end

  `include "hashed_timing_wheel_defines.svh"
  `HTW_ASSERT(a_no_overflow, clk, rst, count != 2'd3, "queue count out of range")
  `HTW_ASSERT(a_valid_cnt, clk, rst, q_valid == (count != 2'd0), "queue valid mismatch")
  `HTW_ASSERT(a_full_stall, clk, rst, (count == 2'd2) |-> !s_ready, "queue accepts when full")
endmodule

/* src/htw_back.sv */
// Command engine: scans the timer table, places targets and emits results.
module htw_back #(
  parameter int MAX_TIMERS = 16,
  parameter int MAX_SLOTS  = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  htw_pkg::cmd_t  q_cmd,
  input  logic [10:0]    wheel_slots,
  input  logic [15:0]    tick_period,
  output logic           m_valid,
  input  logic           m_ready,
  output htw_pkg::res_t  m_res
);
  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int SW = $clog2(MAX_SLOTS);
  localparam int NW = SW + 1;
  localparam int TW = 32 + NW;

  // Entry table.
  logic [MAX_TIMERS-1:0] live;
  logic                  rep   [MAX_TIMERS];
  logic [23:0]           per   [MAX_TIMERS];
  logic [SW-1:0]         eslot [MAX_TIMERS];
  logic [31:0]           ecyc  [MAX_TIMERS];

  htw_pkg::state_t state, state_next;
  htw_pkg::cmd_t   cmd;
  logic [SW-1:0]   slot_now;
  logic [31:0]     cycle_now;
  logic [IW-1:0]   idx;
  logic [5:0]      dcnt;
  logic [23:0]     quo;
  logic [15:0]     rem;
  logic [TW-1:0]   base;
  logic [TW-1:0]   tgt;
  logic [TW-1:0]   trem;
  logic [NW-1:0]   nsl;
  logic [15:0]     tp;
  logic            out_pend;
  htw_pkg::res_t   out_res;
  logic            pend_v;
  htw_pkg::res_t   pend_r;

  // Effective configuration.
  always_comb begin
    if (wheel_slots < 11'd2) nsl = NW'(2);
    else if ({21'd0, wheel_slots} > 32'(MAX_SLOTS)) nsl = NW'(MAX_SLOTS);
    else nsl = NW'(wheel_slots);
    tp = (tick_period == 16'd0) ? 16'd1 : tick_period;
  end

  assign q_ready = (state == htw_pkg::ST_IDLE);
  assign m_valid = out_pend;
  assign m_res   = out_res;

  // Lowest free entry.
  logic [IW-1:0] free_id;
  logic          free_ok;
  always_comb begin
    free_id = '0;
    free_ok = 1'b0;
    for (int k = MAX_TIMERS - 1; k >= 0; k--) begin
      if (!live[k]) begin
        free_id = IW'(k);
        free_ok = 1'b1;
      end
    end
  end

  logic hit;
  assign hit = live[idx] && (eslot[idx] == slot_now) && (ecyc[idx] == cycle_now);

  // The scan waits while a held result cannot move into a busy output register.
  logic scan_wait;
  assign scan_wait = pend_v && out_pend && !m_ready;

  // Next slot position; beyond the slot count it is reduced by a remainder pass.
  logic [NW-1:0] slot_inc;
  logic          adv_over;
  assign slot_inc = {1'b0, slot_now} + NW'(1);
  assign adv_over = slot_inc > nsl;

  logic [16:0] rsub;
  assign rsub = {rem, quo[23]} - {1'b0, tp};
  logic [TW:0] tsub;
  assign tsub = {trem[TW-1:0], tgt[TW-1]} - {{(TW+1-NW){1'b0}}, nsl};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      htw_pkg::ST_IDLE: if (q_valid && q_ready) begin
        case (q_cmd.op)
          htw_pkg::OP_TICK: state_next = htw_pkg::ST_ADV;
          htw_pkg::OP_REG:  state_next = htw_pkg::ST_MUL;
          default:          state_next = htw_pkg::ST_IDLE;
        endcase
      end
      htw_pkg::ST_ADV: state_next = adv_over ? htw_pkg::ST_WRAP : htw_pkg::ST_MUL;
      htw_pkg::ST_WRAP: if (dcnt == 6'(NW - 1)) state_next = htw_pkg::ST_WRAP_DONE;
      htw_pkg::ST_WRAP_DONE: state_next = htw_pkg::ST_MUL;
      htw_pkg::ST_MUL: state_next = (cmd.op == htw_pkg::OP_REG) ?
        (free_ok ? htw_pkg::ST_DIV_INIT : htw_pkg::ST_EMIT) : htw_pkg::ST_SCAN;
      htw_pkg::ST_SCAN: begin
        if (scan_wait) state_next = htw_pkg::ST_SCAN;
        else if (hit && rep[idx]) state_next = htw_pkg::ST_DIV_INIT;
        else if (idx == IW'(MAX_TIMERS - 1)) state_next = htw_pkg::ST_EMIT;
      end
      htw_pkg::ST_DIV_INIT: state_next = htw_pkg::ST_DIV;
      htw_pkg::ST_DIV: if (dcnt == 6'd23) state_next = htw_pkg::ST_PLACE_DIV;
      htw_pkg::ST_PLACE_DIV: state_next = htw_pkg::ST_PLACE_RUN;
      htw_pkg::ST_PLACE_RUN: if (dcnt == 6'(TW - 1)) state_next = htw_pkg::ST_PLACE_DONE;
      htw_pkg::ST_PLACE_DONE: state_next = (cmd.op == htw_pkg::OP_REG) ? htw_pkg::ST_EMIT :
        ((idx == IW'(MAX_TIMERS - 1)) ? htw_pkg::ST_EMIT : htw_pkg::ST_SCAN);
      htw_pkg::ST_EMIT: if (!pend_v) state_next = htw_pkg::ST_IDLE;
      default: state_next = htw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and table updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= htw_pkg::ST_IDLE;
      live      <= '0;
      slot_now  <= '0;
      cycle_now <= '0;
      out_pend  <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_pend && m_ready) out_pend <= 1'b0;
      // Hold one result back so that last can be set on the final one.
      if (pend_v && (!out_pend || m_ready) &&
          (state == htw_pkg::ST_EMIT || state == htw_pkg::ST_SCAN)) begin
        if (state == htw_pkg::ST_EMIT) begin
          out_res  <= '{kind: pend_r.kind, entry_id: pend_r.entry_id, last: 1'b1};
          out_pend <= 1'b1;
          pend_v   <= 1'b0;
        end
      end
      case (state)
        htw_pkg::ST_IDLE: if (q_valid && q_ready) begin
          cmd <= q_cmd;
          idx <= '0;
          if (q_cmd.op == htw_pkg::OP_DEREG && 32'(q_cmd.timer_id) < 32'(MAX_TIMERS))
            live[IW'(q_cmd.timer_id)] <= 1'b0;
          if (q_cmd.op == htw_pkg::OP_RESCHED && 32'(q_cmd.timer_id) < 32'(MAX_TIMERS) &&
              live[IW'(q_cmd.timer_id)] && q_cmd.interval != 24'd0)
            per[IW'(q_cmd.timer_id)] <= q_cmd.interval;
        end
        htw_pkg::ST_ADV: begin
          if (slot_inc == nsl) begin
            slot_now  <= '0;
            cycle_now <= cycle_now + 32'd1;
          end else if (slot_inc < nsl) begin
            slot_now <= slot_now + SW'(1);
          end else begin
            tgt  <= {slot_inc, {(TW-NW){1'b0}}};
            trem <= '0;
            dcnt <= '0;
          end
        end
        // The reduced slot position; a zero remainder starts a new cycle.
        htw_pkg::ST_WRAP_DONE: begin
          slot_now <= trem[SW-1:0];
          if (trem == '0) cycle_now <= cycle_now + 32'd1;
        end
        htw_pkg::ST_MUL: begin
          base <= (TW'(cycle_now) * TW'(nsl)) + TW'(slot_now);
          if (cmd.op == htw_pkg::OP_REG) begin
            if (free_ok) begin
              idx <= free_id;
              live[free_id] <= 1'b1;
              rep[free_id] <= cmd.recurring;
              per[free_id] <= cmd.interval;
            end else begin
              pend_v <= 1'b1;
              pend_r <= '{kind: htw_pkg::KIND_FULL, entry_id: 4'd0, last: 1'b1};
            end
          end
        end
        htw_pkg::ST_SCAN: if (!scan_wait) begin
          if (hit) begin
            if (pend_v) begin
              out_res  <= pend_r;
              out_pend <= 1'b1;
            end
            pend_v <= 1'b1;
            pend_r <= '{kind: htw_pkg::KIND_FIRED, entry_id: 4'(idx), last: 1'b0};
            if (!rep[idx]) live[idx] <= 1'b0;
          end
          if (!(hit && rep[idx]) && idx != IW'(MAX_TIMERS - 1)) idx <= idx + IW'(1);
        end
        htw_pkg::ST_DIV_INIT: begin
          quo  <= per[idx];
          rem  <= '0;
          dcnt <= '0;
        end
        // Restoring division of the period by the tick period, one bit a cycle.
        htw_pkg::ST_DIV: begin
          if (!rsub[16]) rem <= rsub[15:0];
          else rem <= {rem[14:0], quo[23]};
          quo  <= {quo[22:0], !rsub[16]};
          dcnt <= dcnt + 6'd1;
        end
        htw_pkg::ST_PLACE_DIV: begin
          tgt  <= base + TW'(quo);
          trem <= '0;
          dcnt <= '0;
        end
        // Split a value by the slot count, one bit a cycle.
        htw_pkg::ST_PLACE_RUN, htw_pkg::ST_WRAP: begin
          if (!tsub[TW]) trem <= tsub[TW-1:0];
          else trem <= {trem[TW-2:0], tgt[TW-1]};
          tgt  <= {tgt[TW-2:0], !tsub[TW]};
          dcnt <= dcnt + 6'd1;
        end
        htw_pkg::ST_PLACE_DONE: begin
          ecyc[idx]  <= tgt[31:0];
          eslot[idx] <= trem[SW-1:0];
          if (cmd.op == htw_pkg::OP_REG) begin
            pend_v <= 1'b1;
            pend_r <= '{kind: htw_pkg::KIND_REGISTERED, entry_id: 4'(idx), last: 1'b1};
          end else if (idx != IW'(MAX_TIMERS - 1)) begin
            idx <= idx + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `include "hashed_timing_wheel_defines.svh"
  `HTW_ASSERT(a_out_hold, clk, rst, (m_valid && !m_ready) |=> m_valid, "result dropped")
  `HTW_ASSERT(a_out_stable, clk, rst, (m_valid && !m_ready) |=> $stable(m_res), "result changed")
  `HTW_ASSERT(a_slot_range, clk, rst, {1'b0, slot_now} < NW'(MAX_SLOTS), "slot out of range")
endmodule

/* src/hashed_timing_wheel.sv */
// Result of a register: its target is divided and placed first; a full table skips the division.
// A tick scans all entries and re-places each recurring entry that fires.
// Deregister and reschedule update the entry table when accepted and give no result.
// One command at a time: a register occupies the engine through its serial divisions.
// A stalled result holds the engine; a two-entry input queue decouples the stream.
// Synchronous reset clears the wheel position, all live bits and config to defaults.
module hashed_timing_wheel #(
  parameter int MAX_TIMERS = 16,
  parameter int MAX_SLOTS  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // op[1:0], timer_id[5:2], interval[29:6], recurring[30]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // kind[1:0], entry_id[5:2], zeros above
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [10:0] wheel_slots;
  logic [15:0] tick_period;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_slots <= 11'd1024;
      tick_period <= 16'd1;
    end else if (cfg_we) begin
      if (cfg_index == htw_pkg::CFG_WHEEL_SLOTS) wheel_slots <= cfg_data[10:0];
      else tick_period <= cfg_data;
    end
  end

  htw_pkg::cmd_t s_cmd, q_cmd;
  htw_pkg::res_t res;
  logic          q_valid, q_ready;

  assign s_cmd = '{op: s_tdata[1:0], timer_id: s_tdata[5:2], interval: s_tdata[29:6],
                   recurring: s_tdata[30]};

  htw_front u_front (
    .clk, .rst, .s_valid(s_tvalid), .s_ready(s_tready), .s_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  htw_back #(.MAX_TIMERS(MAX_TIMERS), .MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .wheel_slots, .tick_period,
    .m_valid(m_tvalid), .m_ready(m_tready), .m_res(res)
  );

  assign m_tdata = {2'b00, res.entry_id, res.kind};
  assign m_tlast = res.last;
endmodule
